@@ sv/exlex_pkg.sv @@
// Shared types, codes and character classes for the expression lexer.
// No dependencies; used by exlex_step and expression_lexer_core.
`default_nettype none

package exlex_pkg;

  typedef enum logic [3:0] {
    TokPlus    = 4'd0,
    TokMinus   = 4'd1,
    TokStar    = 4'd2,
    TokSlash   = 4'd3,
    TokCaret   = 4'd4,
    TokOpen    = 4'd5,
    TokClose   = 4'd6,
    TokComma   = 4'd7,
    TokNumber  = 4'd8,
    TokIdent   = 4'd9,
    TokInvalid = 4'd10,
    TokEnd     = 4'd11
  } token_kind_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_mark;
  } in_beat_t;

  typedef struct packed {
    token_kind_e token_kind;
    logic [15:0] start_column;
    logic [7:0]  token_length;
    logic        last_of_run;
  } out_beat_t;

  // Tokens produced by one character: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    out_beat_t  first;
    out_beat_t  second;
  } step_res_t;

  localparam logic [2:0] ModeStart = 3'd0;
  localparam logic [2:0] ModeInt   = 3'd1;
  localparam logic [2:0] ModeDot   = 3'd2;
  localparam logic [2:0] ModeFrac  = 3'd3;
  localparam logic [2:0] ModeIdent = 3'd4;

  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] CharUscore = 8'h5F;
  localparam logic [7:0] CharUpA    = 8'h41;
  localparam logic [7:0] CharUpZ    = 8'h5A;
  localparam logic [7:0] CharLoA    = 8'h61;
  localparam logic [7:0] CharLoZ    = 8'h7A;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharCaret  = 8'h5E;
  localparam logic [7:0] CharOpen   = 8'h28;
  localparam logic [7:0] CharClose  = 8'h29;
  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic logic is_alpha_us(input logic [7:0] c);
    return ((c >= CharUpA) && (c <= CharUpZ)) || ((c >= CharLoA) && (c <= CharLoZ)) ||
           (c == CharUscore);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CharSpace) || (c == CharTab);
  endfunction

endpackage

`default_nettype wire

@@ sv/exlex_step.sv @@
// Next-state and token logic for one character of the expression lexer.
// Depends on exlex_pkg; purely combinational, state lives in the top level.
`default_nettype none

module exlex_step #(
  parameter int COLUMN_WIDTH = 16,
  parameter int LENGTH_WIDTH = 8
) (
  input  logic [2:0]              mode_i,
  input  logic [COLUMN_WIDTH-1:0] col_i,
  input  logic [COLUMN_WIDTH-1:0] start_i,
  input  logic [LENGTH_WIDTH-1:0] len_i,
  input  exlex_pkg::in_beat_t     beat_i,
  output logic [2:0]              mode_o,
  output logic [COLUMN_WIDTH-1:0] col_o,
  output logic [COLUMN_WIDTH-1:0] start_o,
  output logic [LENGTH_WIDTH-1:0] len_o,
  output exlex_pkg::step_res_t    res_o
);

  localparam int ColExtW = (COLUMN_WIDTH > 16) ? COLUMN_WIDTH : 16;
  localparam int LenExtW = (LENGTH_WIDTH > 8) ? LENGTH_WIDTH : 8;

  logic [7:0]              c;
  logic                    eof;
  logic                    dig;
  logic [COLUMN_WIDTH-1:0] col1;
  logic [LENGTH_WIDTH-1:0] len_inc;
  logic [LENGTH_WIDTH-1:0] pend_len;
  logic [ColExtW-1:0]      col1_ext;
  logic [ColExtW-1:0]      start_ext;
  logic [LenExtW-1:0]      pend_len_ext;

  // Start-mode handling, shared by the direct path and the reprocess path.
  logic                    sp_emit;
  exlex_pkg::token_kind_e  sp_kind;
  logic [2:0]              sp_mode;
  logic [COLUMN_WIDTH-1:0] sp_start;
  logic [LENGTH_WIDTH-1:0] sp_len;
  exlex_pkg::out_beat_t    sp_beat;
  exlex_pkg::out_beat_t    pend_beat;

  assign c        = beat_i.char_code;
  assign eof      = beat_i.end_mark;
  assign dig      = exlex_pkg::is_digit(c);
  assign col1     = (!eof && (col_i != {COLUMN_WIDTH{1'b1}})) ? col_i + 1'b1 : col_i;
  assign len_inc  = (len_i != {LENGTH_WIDTH{1'b1}}) ? len_i + 1'b1 : len_i;
  // A dot left dangling swallows the offending character into the invalid token.
  assign pend_len = ((mode_i == exlex_pkg::ModeDot) && !eof) ? len_inc : len_i;

  assign col1_ext     = ColExtW'(col1);
  assign start_ext    = ColExtW'(start_i);
  assign pend_len_ext = LenExtW'(pend_len);

  always_comb begin
    sp_emit  = 1'b0;
    sp_kind  = exlex_pkg::TokInvalid;
    sp_mode  = exlex_pkg::ModeStart;
    sp_start = start_i;
    sp_len   = len_i;
    if (eof) begin
      sp_emit = 1'b1;
      sp_kind = exlex_pkg::TokEnd;
    end else if (!exlex_pkg::is_blank(c)) begin
      sp_start = col1;
      sp_len   = LENGTH_WIDTH'(1);
      sp_emit  = 1'b1;
      case (c)
        exlex_pkg::CharPlus:  sp_kind = exlex_pkg::TokPlus;
        exlex_pkg::CharMinus: sp_kind = exlex_pkg::TokMinus;
        exlex_pkg::CharStar:  sp_kind = exlex_pkg::TokStar;
        exlex_pkg::CharSlash: sp_kind = exlex_pkg::TokSlash;
        exlex_pkg::CharCaret: sp_kind = exlex_pkg::TokCaret;
        exlex_pkg::CharOpen:  sp_kind = exlex_pkg::TokOpen;
        exlex_pkg::CharClose: sp_kind = exlex_pkg::TokClose;
        exlex_pkg::CharComma: sp_kind = exlex_pkg::TokComma;
        default: begin
          if (dig) begin
            sp_emit = 1'b0;
            sp_mode = exlex_pkg::ModeInt;
          end else if (c == exlex_pkg::CharDot) begin
            sp_emit = 1'b0;
            sp_mode = exlex_pkg::ModeDot;
          end else if (exlex_pkg::is_alpha_us(c)) begin
            sp_emit = 1'b0;
            sp_mode = exlex_pkg::ModeIdent;
          end
        end
      endcase
    end
  end

  always_comb begin
    sp_beat.token_kind   = sp_kind;
    sp_beat.start_column = col1_ext[15:0];
    sp_beat.token_length = eof ? 8'd0 : 8'd1;
    sp_beat.last_of_run  = 1'b1;

    pend_beat.token_kind   = exlex_pkg::TokNumber;
    pend_beat.start_column = start_ext[15:0];
    pend_beat.token_length = pend_len_ext[7:0];
    pend_beat.last_of_run  = 1'b1;
  end

  always_comb begin
    mode_o       = mode_i;
    col_o        = col1;
    start_o      = start_i;
    len_o        = len_i;
    res_o.count  = 2'd0;
    res_o.first  = sp_beat;
    res_o.second = sp_beat;

    unique case (mode_i)
      exlex_pkg::ModeInt, exlex_pkg::ModeFrac, exlex_pkg::ModeIdent: begin
        if (!eof && (mode_i == exlex_pkg::ModeIdent) && (dig || exlex_pkg::is_alpha_us(c))) begin
          len_o = len_inc;
        end else if (!eof && (mode_i != exlex_pkg::ModeIdent) && dig) begin
          len_o = len_inc;
        end else if (!eof && (mode_i == exlex_pkg::ModeInt) && (c == exlex_pkg::CharDot)) begin
          len_o  = len_inc;
          mode_o = exlex_pkg::ModeDot;
        end else begin
          // Close the pending token, then run the same character from start mode.
          res_o.first            = pend_beat;
          res_o.first.token_kind = (mode_i == exlex_pkg::ModeIdent) ?
                                   exlex_pkg::TokIdent : exlex_pkg::TokNumber;
          res_o.first.last_of_run = !sp_emit;
          res_o.count            = sp_emit ? 2'd2 : 2'd1;
          mode_o                 = sp_mode;
          start_o                = sp_start;
          len_o                  = sp_len;
        end
      end
      exlex_pkg::ModeDot: begin
        if (!eof && dig) begin
          len_o  = len_inc;
          mode_o = exlex_pkg::ModeFrac;
        end else begin
          res_o.first            = pend_beat;
          res_o.first.token_kind = exlex_pkg::TokInvalid;
          res_o.count            = 2'd1;
          len_o                  = pend_len;
          mode_o                 = exlex_pkg::ModeStart;
        end
      end
      default: begin
        res_o.count = sp_emit ? 2'd1 : 2'd0;
        mode_o      = sp_mode;
        start_o     = sp_start;
        len_o       = sp_len;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/expression_lexer_core.sv @@
// Expression lexer top level: input register, lexer state, two-entry result buffer.
// Depends on exlex_pkg and exlex_step.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------
//   in      | sink      | in_valid_i/in_ready_o | exlex_pkg::in_beat_t
//   out     | source    | out_valid_o/out_ready_i | exlex_pkg::out_beat_t
//
// One character per cycle while the result buffer accepts: a beat is registered in the
// input register, then the lexer step updates the state and loads zero, one or two
// tokens into the result buffer, which shows its head on the next cycle.
// The load waits until the buffer is empty or drains this cycle, so a character
// that closes a token and starts another can hold off the next character.
// Reset clears all control state and puts the lexer in start mode at column zero.
`default_nettype none

module expression_lexer_core #(
  parameter int COLUMN_WIDTH = 16,
  parameter int LENGTH_WIDTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  exlex_pkg::in_beat_t  in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output exlex_pkg::out_beat_t out_o
);

  logic                    in_vq;
  exlex_pkg::in_beat_t     in_q;

  logic [2:0]              mode_q, mode_d;
  logic [COLUMN_WIDTH-1:0] col_q, col_d;
  logic [COLUMN_WIDTH-1:0] start_q, start_d;
  logic [LENGTH_WIDTH-1:0] len_q, len_d;

  exlex_pkg::out_beat_t    head_q, tail_q;
  logic [1:0]              cnt_q;

  exlex_pkg::step_res_t    step_res;
  logic                    pop;
  logic                    load;

  exlex_step #(
    .COLUMN_WIDTH(COLUMN_WIDTH),
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_step (
    .mode_i (mode_q),
    .col_i  (col_q),
    .start_i(start_q),
    .len_i  (len_q),
    .beat_i (in_q),
    .mode_o (mode_d),
    .col_o  (col_d),
    .start_o(start_d),
    .len_o  (len_d),
    .res_o  (step_res)
  );

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_o       = head_q;
  assign pop         = out_valid_o && out_ready_i;
  assign load        = in_vq && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));
  assign in_ready_o  = !in_vq || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq   <= 1'b0;
      mode_q  <= exlex_pkg::ModeStart;
      col_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      cnt_q   <= 2'd0;
    end else begin
      if (in_ready_o) begin
        in_vq <= in_valid_i;
      end
      if (load) begin
        mode_q  <= mode_d;
        col_q   <= col_d;
        start_q <= start_d;
        len_q   <= len_d;
        cnt_q   <= step_res.count;
      end else if (pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_i;
    end
    if (load) begin
      head_q <= step_res.first;
      tail_q <= step_res.second;
    end else if (pop) begin
      // advance the second token of a pair
      head_q <= tail_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");

  a_no_load_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !load)
    else $error("step loaded over a held token pair");

  a_pair_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && step_res.count == 2'd2 |=> cnt_q == 2'd2 && !out_o.last_of_run)
    else $error("token pair not held in buffer");

  a_single_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd1 |-> out_o.last_of_run)
    else $error("final buffered token lacks last_of_run");
`endif

endmodule

`default_nettype wire

@@ tb/expression_lexer_checker.sv @@
// Token checker for expression_lexer_core: watches the character and token channels,
// predicts the tokens of each accepted character and compares them in order.
// Depends on exlex_pkg for the beat types, token kinds, mode codes and character codes.
module expression_lexer_checker
  import exlex_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_beat_t  in_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_beat_t out_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        chars_taken_o,
  output int        tokens_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Scanner state
  logic [2:0]  scan_mode;
  logic [15:0] column_now;
  logic [15:0] token_col;
  logic [7:0]  token_len;

  out_beat_t expected_tokens[$];
  int        errs;
  int        taken;
  int        seen;

  function automatic bit digit_char(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic bit word_char(input logic [7:0] c);
    return ((c >= CharUpA) && (c <= CharUpZ)) || ((c >= CharLoA) && (c <= CharLoZ)) ||
           (c == CharUscore);
  endfunction

  // Single-character tokens; anything else maps to invalid
  function automatic token_kind_e punct_of(input logic [7:0] c);
    case (c)
      CharPlus:  return TokPlus;
      CharMinus: return TokMinus;
      CharStar:  return TokStar;
      CharSlash: return TokSlash;
      CharCaret: return TokCaret;
      CharOpen:  return TokOpen;
      CharClose: return TokClose;
      CharComma: return TokComma;
      default:   return TokInvalid;
    endcase
  endfunction

  function automatic out_beat_t make_token(input token_kind_e kind, input logic [15:0] col,
                                           input logic [7:0] len);
    out_beat_t t;
    t.token_kind   = kind;
    t.start_column = col;
    t.token_length = len;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  function automatic void grow_token();
    if (token_len != '1) token_len++;
  endfunction

  task automatic lex_char(input in_beat_t b);
    logic [7:0]  c;
    bit          eom;
    bit          again;
    int          n;
    out_beat_t   made [2];
    token_kind_e k;
    c     = b.char_code;
    eom   = b.end_mark;
    n     = 0;
    again = 1'b1;
    if (!eom && column_now != '1) column_now++;
    while (again) begin
      again = 1'b0;
      case (scan_mode)
        ModeInt, ModeFrac: begin
          if (!eom && digit_char(c)) begin
            grow_token();
          end else if (scan_mode == ModeInt && !eom && c == CharDot) begin
            grow_token();
            scan_mode = ModeDot;
          end else begin
            // Close the number and rescan this character
            made[n] = make_token(TokNumber, token_col, token_len);
            n++;
            scan_mode = ModeStart;
            again = 1'b1;
          end
        end
        ModeDot: begin
          if (!eom && digit_char(c)) begin
            grow_token();
            scan_mode = ModeFrac;
          end else begin
            // The offending character is swallowed into the invalid token
            if (!eom) grow_token();
            made[n] = make_token(TokInvalid, token_col, token_len);
            n++;
            scan_mode = ModeStart;
          end
        end
        ModeIdent: begin
          if (!eom && (word_char(c) || digit_char(c))) begin
            grow_token();
          end else begin
            made[n] = make_token(TokIdent, token_col, token_len);
            n++;
            scan_mode = ModeStart;
            again = 1'b1;
          end
        end
        default: begin
          scan_mode = ModeStart;
          if (eom) begin
            made[n] = make_token(TokEnd, column_now, 8'd0);
            n++;
          end else if (!(c == CharSpace || c == CharTab)) begin
            token_col = column_now;
            token_len = 8'd1;
            k = punct_of(c);
            if (k != TokInvalid) begin
              made[n] = make_token(k, token_col, 8'd1);
              n++;
            end else if (digit_char(c)) begin
              scan_mode = ModeInt;
            end else if (c == CharDot) begin
              scan_mode = ModeDot;
            end else if (word_char(c)) begin
              scan_mode = ModeIdent;
            end else begin
              made[n] = make_token(TokInvalid, token_col, 8'd1);
              n++;
            end
          end
        end
      endcase
    end
    if (n > 0) made[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_tokens.push_back(made[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_beat_t want;
    if (!rst_ni) begin
      scan_mode  = ModeStart;
      column_now = '0;
      token_col  = '0;
      token_len  = '0;
      expected_tokens.delete();
      errs  = 0;
      taken = 0;
      seen  = 0;
    end else begin
      // Tokens trail their character through the input register and result buffer: check outputs first
      if (out_valid_i && out_ready_i) begin
        seen++;
        if (expected_tokens.size() == 0) begin
          $error("unexpected token: kind %0d column %0d length %0d", out_i.token_kind,
                 out_i.start_column, out_i.token_length);
          errs++;
        end else begin
          want = expected_tokens.pop_front();
          if (out_i.token_kind !== want.token_kind) begin
            $error("token_kind: expected %0d, got %0d", want.token_kind, out_i.token_kind);
            errs++;
          end
          if (out_i.start_column !== want.start_column) begin
            $error("start_column: expected %0d, got %0d", want.start_column,
                   out_i.start_column);
            errs++;
          end
          if (out_i.token_length !== want.token_length) begin
            $error("token_length: expected %0d, got %0d", want.token_length,
                   out_i.token_length);
            errs++;
          end
          if (out_i.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run, out_i.last_of_run);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        taken++;
        lex_char(in_i);
      end
    end
    fail_count_o  <= errs;
    pending_o     <= expected_tokens.size();
    chars_taken_o <= taken;
    tokens_seen_o <= seen;
  end

endmodule

@@ tb/expression_lexer_core_test.sv @@
// Top of the expression lexer testbench: clock, reset, character stimulus and token sink.
// Depends on exlex_pkg, expression_lexer_core and expression_lexer_checker.
module expression_lexer_core_test
  import exlex_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 1000000;
  localparam int RandomItems = 350;
  localparam int HoldCycles  = 400;
  localparam int HoldAfter   = 60;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  int fails;
  int pending;
  int chars_taken;
  int tokens_seen;

  int cycles     = 0;
  int beats_sent = 0;
  int burst_left = 0;
  bit gaps_on    = 1'b0;
  int random_cnt = 0;

  expression_lexer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data)
  );

  expression_lexer_checker token_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_i          (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_i         (out_data),
    .fail_count_o  (fails),
    .pending_o     (pending),
    .chars_taken_o (chars_taken),
    .tokens_seen_o (tokens_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Token sink: changing stall styles, plus one long hold-off to back up the input
  initial begin : sink
    int  style;
    int  style_left;
    int  tick;
    bit  held;
    style_left = 0;
    style      = 0;
    tick       = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (!held && tokens_seen >= HoldAfter) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      if (style_left == 0) begin
        style      = $urandom_range(0, 3);
        style_left = $urandom_range(50, 300);
      end
      style_left--;
      case (style)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (tick % 5 != 0);
      endcase
    end
  end

  task automatic send_beat(input in_beat_t b);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send_beat('{char_code: c, end_mark: 1'b0});
  endtask

  task automatic send_end();
    send_beat('{char_code: 8'($urandom_range(0, 255)), end_mark: 1'b1});
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Drop valid, then hold until the checker has seen every beat and every predicted token
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0 || chars_taken != beats_sent) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_digit();
    return CharZero + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_word_char(input bit with_digits);
    int r;
    r = $urandom_range(0, with_digits ? 62 : 52);
    if (r < 26) return CharUpA + 8'(r);
    if (r < 52) return CharLoA + 8'(r - 26);
    if (r == 52) return CharUscore;
    return CharZero + 8'(r - 53);
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 7))
      0:       return CharPlus;
      1:       return CharMinus;
      2:       return CharStar;
      3:       return CharSlash;
      4:       return CharCaret;
      5:       return CharOpen;
      6:       return CharClose;
      default: return CharComma;
    endcase
  endfunction

  // One lexeme of a plausible expression, or a blank, an end mark or a noise byte
  task automatic random_fragment();
    int pick;
    bit lead_dot;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      lead_dot = ($urandom_range(0, 4) == 0);
      if (lead_dot) begin
        send_char(CharDot);
        random_cnt++;
        repeat ($urandom_range(0, 3)) begin
          send_char(pick_digit());
          random_cnt++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_char(pick_digit());
          random_cnt++;
        end
        if ($urandom_range(0, 2) == 0) begin
          send_char(CharDot);
          random_cnt++;
          repeat ($urandom_range(0, 3)) begin
            send_char(pick_digit());
            random_cnt++;
          end
        end
      end
    end else if (pick < 50) begin
      send_char(pick_word_char(1'b0));
      random_cnt++;
      repeat ($urandom_range(0, 5)) begin
        send_char(pick_word_char(1'b1));
        random_cnt++;
      end
    end else if (pick < 70) begin
      send_char(pick_op());
      random_cnt++;
    end else if (pick < 82) begin
      repeat ($urandom_range(1, 2)) send_char($urandom_range(0, 1) ? CharSpace : CharTab);
    end else if (pick < 87) begin
      send_end();
      random_cnt++;
    end else begin
      send_char(8'($urandom_range(0, 255)));
      random_cnt++;
    end
  endtask

  initial begin : stimulus
    bit mid_pause;
    mid_pause = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every operator, blanks, number forms, broken dots, end marks
    send_text("+-*/^(),\t12.5_a9");
    send_end();
    send_text(".x");
    send_char(8'h00);
    send_char(8'hFF);
    send_text(".5");
    send_end();
    send_char(CharDot);
    send_end();
    send_end();
    wait_drained();

    gaps_on = 1'b1;
    while (random_cnt < RandomItems) begin
      random_fragment();
      if (!mid_pause && random_cnt >= RandomItems / 2) begin
        mid_pause = 1'b1;
        wait_drained();
      end
    end

    // Long identifier pushes the length counter to saturation
    send_char(CharUscore);
    repeat (259) send_char(pick_word_char(1'b1));
    send_char(CharComma);
    repeat (20) send_char(pick_digit());
    send_char(CharDot);
    repeat (3) send_char(pick_digit());
    send_end();

    gaps_on = 1'b0;
    send_text("x1+2.5 @.");
    send_end();
    send_end();

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d character beats and %0d tokens: operators, numbers, identifiers,",
             beats_sent, tokens_seen);
    $display("broken dots, noise bytes, end marks, and length saturation.");
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
